@@ sv/clpr_pkg.sv @@
// clpr_pkg: shared widths, conversion constants and item types for the
// chroma line-pair colour rebuild; depends on nothing
`default_nettype none

package clpr_pkg;

	localparam int COL_W = 9;
	localparam int PIX_W = 8;

	// depth of the queue between front and back, and of the result queue
	localparam int QUEUE_DEPTH = 4;
	localparam int OUT_DEPTH   = 4;

	// integer bt.601 coefficients and offsets
	localparam int K_Y     = 298;
	localparam int K_RV    = 409;
	localparam int K_GU    = 100;
	localparam int K_GV    = 208;
	localparam int K_BU    = 516;
	localparam int Y_OFS   = 16;
	localparam int C_OFS   = 128;
	localparam int ROUND   = 128;
	localparam int PIX_MAX = 255;

	// one emitting column, with the stored line's entry attached
	typedef struct packed {
		logic [COL_W-1:0] column;
		logic [PIX_W-1:0] luma_cur;
		logic [PIX_W-1:0] chroma_u;
		logic [PIX_W-1:0] luma_prev;
		logic [PIX_W-1:0] chroma_v;
	} pair_t;

	// one rgb result
	typedef struct packed {
		logic             row_select;
		logic [COL_W-1:0] column;
		logic [PIX_W-1:0] red;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] blue;
		logic             last;
	} pix_t;

endpackage

`default_nettype wire

@@ sv/clpr_fifo.sv @@
// clpr_fifo: small register queue with occupancy count
// generic width and depth; no package dependency
`default_nettype none

module clpr_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       wr_en,
	input  wire logic [WIDTH-1:0]           wr_data,
	input  wire logic                       rd_en,
	output logic      [WIDTH-1:0]           rd_data,
	output logic                            empty,
	output logic                            full,
	output logic      [$clog2(DEPTH+1)-1:0] count
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] store_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign rd_data = store_q[rd_ptr_q];
	assign empty   = (count_q == '0);
	assign full    = (count_q == CNT_W'(DEPTH));
	assign count   = count_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

@@ sv/clpr_front.sv @@
// clpr_front: takes input items, keeps red-difference lines in the line
// store and forwards emitting columns with their stored entry; uses clpr_pkg
`default_nettype none

module clpr_front #(
	parameter int LINE_WIDTH = 320
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          push,
	output logic                               full,
	input  wire logic [clpr_pkg::COL_W-1:0]    column,
	input  wire logic [clpr_pkg::PIX_W-1:0]    luma,
	input  wire logic [clpr_pkg::PIX_W-1:0]    chroma,
	input  wire logic                          chroma_kind,
	output logic                               q_push,
	output clpr_pkg::pair_t                    q_data,
	input  wire logic                          q_full
);

	localparam int          ADDR_W = (LINE_WIDTH > 1) ? $clog2(LINE_WIDTH) : 1;
	localparam logic [31:0] LW_U   = 32'(LINE_WIDTH);

	logic                             accept;
	logic                             in_range;
	logic [ADDR_W-1:0]                addr;
	logic [2*clpr_pkg::PIX_W-1:0]     line_mem_q [LINE_WIDTH];
	logic [2*clpr_pkg::PIX_W-1:0]     rd_s1;
	logic                             valid_s1;
	logic [clpr_pkg::COL_W-1:0]       col_s1;
	logic [clpr_pkg::PIX_W-1:0]       luma_s1;
	logic [clpr_pkg::PIX_W-1:0]       chroma_s1;

	assign in_range = (32'(column) < LW_U);
	assign addr     = ADDR_W'(column);
	assign full     = valid_s1 && q_full;
	assign accept   = push && !full;
	assign q_push   = valid_s1 && !q_full;

	always_comb begin
		q_data.column    = col_s1;
		q_data.luma_cur  = luma_s1;
		q_data.chroma_u  = chroma_s1;
		q_data.luma_prev = rd_s1[2*clpr_pkg::PIX_W-1:clpr_pkg::PIX_W];
		q_data.chroma_v  = rd_s1[clpr_pkg::PIX_W-1:0];
	end

	// line store: written by storing columns, read by emitting ones
	always_ff @(posedge clk) begin
		if (accept && in_range && !chroma_kind) begin
			line_mem_q[addr] <= {luma, chroma};
		end
		if (accept && in_range && chroma_kind) begin
			rd_s1 <= line_mem_q[addr];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			col_s1    <= column;
			luma_s1   <= luma;
			chroma_s1 <= chroma;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= in_range && chroma_kind;
		end else if (q_push) begin
			valid_s1 <= 1'b0;
		end
	end

endmodule

`default_nettype wire

@@ sv/clpr_back.sv @@
// clpr_back: two rgb results per queued column, one a cycle while the
// result queue has room, via product and sum-clamp stages; uses clpr_pkg
`default_nettype none

module clpr_back (
	input  wire logic                                      clk,
	input  wire logic                                      arst_n,
	input  wire logic                                      q_empty,
	input  wire clpr_pkg::pair_t                           q_data,
	output logic                                           q_pop,
	output logic                                           o_push,
	output clpr_pkg::pix_t                                 o_data,
	input  wire logic [$clog2(clpr_pkg::OUT_DEPTH+1)-1:0]  o_count
);

	localparam int CNT_W = $clog2(clpr_pkg::OUT_DEPTH + 1) + 1;

	function automatic logic [clpr_pkg::PIX_W-1:0] clamp_pix(input logic signed [20:0] v);
		logic signed [20:0] sh;
		sh = v >>> 8;
		if (sh < 21'sd0) begin
			return '0;
		end else if (sh > 21'(clpr_pkg::PIX_MAX)) begin
			return clpr_pkg::PIX_W'(clpr_pkg::PIX_MAX);
		end
		return sh[clpr_pkg::PIX_W-1:0];
	endfunction

	logic                         issue;
	logic                         phase_q;
	logic [clpr_pkg::PIX_W-1:0]   y_sel;
	logic signed [9:0]            yy;
	logic signed [9:0]            uu;
	logic signed [9:0]            vv;

	logic                         valid_s1;
	logic                         row_s1;
	logic [clpr_pkg::COL_W-1:0]   col_s1;
	logic signed [18:0]           py_s1;
	logic signed [18:0]           prv_s1;
	logic signed [18:0]           pgu_s1;
	logic signed [18:0]           pgv_s1;
	logic signed [18:0]           pbu_s1;

	logic signed [20:0]           r_sum;
	logic signed [20:0]           g_sum;
	logic signed [20:0]           b_sum;

	// issue only when the result queue can take everything in flight
	assign issue = !q_empty &&
		(({1'b0, o_count} + CNT_W'(valid_s1)) < CNT_W'(clpr_pkg::OUT_DEPTH));
	assign q_pop = issue && phase_q;

	// first pass uses the stored line's luma, second the current luma
	assign y_sel = phase_q ? q_data.luma_cur : q_data.luma_prev;
	assign yy    = $signed({2'b00, y_sel}) - 10'sd16;
	assign uu    = $signed({2'b00, q_data.chroma_u}) - 10'(clpr_pkg::C_OFS);
	assign vv    = $signed({2'b00, q_data.chroma_v}) - 10'(clpr_pkg::C_OFS);

	always_ff @(posedge clk) begin
		if (issue) begin
			row_s1 <= phase_q;
			col_s1 <= q_data.column;
			py_s1  <= 19'(yy * clpr_pkg::K_Y);
			prv_s1 <= 19'(vv * clpr_pkg::K_RV);
			pgu_s1 <= 19'(uu * clpr_pkg::K_GU);
			pgv_s1 <= 19'(vv * clpr_pkg::K_GV);
			pbu_s1 <= 19'(uu * clpr_pkg::K_BU);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= 1'b0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= issue;
			if (issue) begin
				phase_q <= !phase_q;
			end
		end
	end

	assign r_sum = 21'(py_s1) + 21'(prv_s1) + 21'(clpr_pkg::ROUND);
	assign g_sum = 21'(py_s1) - 21'(pgu_s1) - 21'(pgv_s1) + 21'(clpr_pkg::ROUND);
	assign b_sum = 21'(py_s1) + 21'(pbu_s1) + 21'(clpr_pkg::ROUND);

	assign o_push = valid_s1;

	always_comb begin
		o_data.row_select = row_s1;
		o_data.column     = col_s1;
		o_data.red        = clamp_pix(r_sum);
		o_data.green      = clamp_pix(g_sum);
		o_data.blue       = clamp_pix(b_sum);
		o_data.last       = row_s1;
	end

endmodule

`default_nettype wire

@@ sv/chroma_line_pair_to_rgb_core.sv @@
// chroma_line_pair_to_rgb_core: top level of the line-pair colour rebuild
// joins front, column queue, converter and result queue; uses clpr_pkg
//
// input side is a queue: an item is taken at a rising edge with push high
// and full low. each item is one sampled column (column, luma, chroma,
// chroma_kind). a red-difference column (chroma_kind low) goes into the line
// store and gives nothing back. a blue-difference column gives two results:
// first the stored line's pixel (row_select low), then the current line's
// pixel (row_select high, last high). columns at or beyond LINE_WIDTH are
// dropped.
// result side is a queue too: the oldest result sits on the ports while
// empty is low and is taken at a rising edge with pop high.
// the first result of an emitting column is visible once it has passed the
// front's read stage, the column queue, the product stage and the result
// queue; the second follows it. storing items are taken one per cycle
// while full is low; an emitting item holds the single converter for two
// results, made one a cycle while the result queue has room. the line store
// is a single-port memory of LINE_WIDTH entries, read as the item is taken.
// when the receiver stalls, results collect in a four-entry result queue
// and emitting columns in a four-entry queue ahead of the converter; full
// rises once both and the front's read stage are taken. reset empties all
// queues; the line store is not cleared and must be written before use.
`default_nettype none

module chroma_line_pair_to_rgb_core #(
	parameter int LINE_WIDTH = 320
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        push,
	output logic                             full,
	input  wire logic [clpr_pkg::COL_W-1:0]  column,
	input  wire logic [clpr_pkg::PIX_W-1:0]  luma,
	input  wire logic [clpr_pkg::PIX_W-1:0]  chroma,
	input  wire logic                        chroma_kind,
	output logic                             empty,
	input  wire logic                        pop,
	output logic                             row_select,
	output logic [clpr_pkg::COL_W-1:0]       out_column,
	output logic [clpr_pkg::PIX_W-1:0]       red,
	output logic [clpr_pkg::PIX_W-1:0]       green,
	output logic [clpr_pkg::PIX_W-1:0]       blue,
	output logic                             last
);

	localparam int PAIR_W = $bits(clpr_pkg::pair_t);
	localparam int PIX_W  = $bits(clpr_pkg::pix_t);
	localparam int QCNT_W = $clog2(clpr_pkg::QUEUE_DEPTH + 1);
	localparam int OCNT_W = $clog2(clpr_pkg::OUT_DEPTH + 1);

	// front to column queue
	logic                  fq_push;
	clpr_pkg::pair_t       fq_data;
	logic                  fq_full;

	// column queue to converter
	logic [PAIR_W-1:0]     q_rd_data;
	clpr_pkg::pair_t       q_head;
	logic                  q_empty;
	logic                  q_pop;
	logic [QCNT_W-1:0]     q_count;

	// converter to result queue
	logic                  o_push;
	clpr_pkg::pix_t        o_data;
	logic [OCNT_W-1:0]     o_count;
	logic                  o_full;
	logic [PIX_W-1:0]      o_rd_data;
	clpr_pkg::pix_t        o_head;

	clpr_front #(
		.LINE_WIDTH(LINE_WIDTH)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.column      (column),
		.luma        (luma),
		.chroma      (chroma),
		.chroma_kind (chroma_kind),
		.q_push      (fq_push),
		.q_data      (fq_data),
		.q_full      (fq_full)
	);

	// emitting columns waiting for the converter
	clpr_fifo #(
		.WIDTH(PAIR_W),
		.DEPTH(clpr_pkg::QUEUE_DEPTH)
	) u_col_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (fq_push),
		.wr_data (fq_data),
		.rd_en   (q_pop),
		.rd_data (q_rd_data),
		.empty   (q_empty),
		.full    (fq_full),
		.count   (q_count)
	);

	assign q_head = clpr_pkg::pair_t'(q_rd_data);

	clpr_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_data  (q_head),
		.q_pop   (q_pop),
		.o_push  (o_push),
		.o_data  (o_data),
		.o_count (o_count)
	);

	// finished results waiting for the receiver; the converter never
	// issues past the free space, so o_full is only for completeness
	clpr_fifo #(
		.WIDTH(PIX_W),
		.DEPTH(clpr_pkg::OUT_DEPTH)
	) u_out_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (o_push && !o_full),
		.wr_data (o_data),
		.rd_en   (pop && !empty),
		.rd_data (o_rd_data),
		.empty   (empty),
		.full    (o_full),
		.count   (o_count)
	);

	assign o_head     = clpr_pkg::pix_t'(o_rd_data);
	assign row_select = o_head.row_select;
	assign out_column = o_head.column;
	assign red        = o_head.red;
	assign green      = o_head.green;
	assign blue       = o_head.blue;
	assign last       = o_head.last;

endmodule

`default_nettype wire

@@ bench/rgb_pair_checker.sv @@
// rgb_pair_checker: watches both queue sides of the line-pair colour rebuild,
// predicts the rgb results of each column item and compares them in order
// depends on clpr_pkg for widths, bt.601 constants and the result type
module rgb_pair_checker
	import clpr_pkg::*;
#(
	parameter int LINE_WIDTH = 320
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic             full,
	input  logic [COL_W-1:0] column,
	input  logic [PIX_W-1:0] luma,
	input  logic [PIX_W-1:0] chroma,
	input  logic             chroma_kind,
	input  logic             empty,
	input  logic             pop,
	input  logic             row_select,
	input  logic [COL_W-1:0] out_column,
	input  logic [PIX_W-1:0] red,
	input  logic [PIX_W-1:0] green,
	input  logic [PIX_W-1:0] blue,
	input  logic             last,
	output int unsigned      mismatches,
	output int unsigned      waiting
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic ROW_PREV = 1'b0;
	localparam logic ROW_CUR  = 1'b1;
	localparam int   SHOWN    = 30;

	logic [PIX_W-1:0] line_luma   [LINE_WIDTH];
	logic [PIX_W-1:0] line_chroma [LINE_WIDTH];
	pix_t             rgb_expected [$];
	int unsigned      error_total = 0;

	function automatic logic [PIX_W-1:0] clamp_pixel(int v);
		if (v < 0)
			return '0;
		if (v > PIX_MAX)
			return PIX_MAX[PIX_W-1:0];
		return v[PIX_W-1:0];
	endfunction

	// integer bt.601 with a floor shift, u from the current line, v stored
	function automatic pix_t bt601_pixel(logic row, logic [COL_W-1:0] col,
			logic [PIX_W-1:0] y, logic [PIX_W-1:0] u, logic [PIX_W-1:0] v,
			logic second);
		int yy;
		int uu;
		int vv;
		pix_t p;
		yy = int'(y) - Y_OFS;
		uu = int'(u) - C_OFS;
		vv = int'(v) - C_OFS;
		p.row_select = row;
		p.column     = col;
		p.red   = clamp_pixel((K_Y * yy + K_RV * vv + ROUND) >>> 8);
		p.green = clamp_pixel((K_Y * yy - K_GU * uu - K_GV * vv + ROUND) >>> 8);
		p.blue  = clamp_pixel((K_Y * yy + K_BU * uu + ROUND) >>> 8);
		p.last  = second;
		return p;
	endfunction

	task automatic report_mismatch(string what);
		if (error_total < SHOWN)
			$display("[%0t] mismatch: %s", $realtime, what);
		error_total++;
	endtask

	task automatic check_field(string name, int got, int want, logic [COL_W-1:0] col);
		if (got != want)
			report_mismatch($sformatf("column %0d %s got %0d want %0d", col, name, got, want));
	endtask

	always @(posedge clk or negedge arst_n) begin
		pix_t want;
		if (!arst_n) begin
			rgb_expected.delete();
			waiting <= 0;
		end else begin
			if (pop && !empty) begin
				if (rgb_expected.size() == 0) begin
					report_mismatch($sformatf("unexpected result at column %0d", out_column));
				end else begin
					want = rgb_expected.pop_front();
					check_field("row_select", row_select, want.row_select, want.column);
					check_field("out_column", out_column, want.column, want.column);
					check_field("red", red, want.red, want.column);
					check_field("green", green, want.green, want.column);
					check_field("blue", blue, want.blue, want.column);
					check_field("last", last, want.last, want.column);
				end
			end
			// columns beyond the line have no store entry and are dropped
			if (push && !full && column < LINE_WIDTH) begin
				if (!chroma_kind) begin
					line_luma[column]   = luma;
					line_chroma[column] = chroma;
				end else begin
					rgb_expected = {rgb_expected, bt601_pixel(ROW_PREV, column,
						line_luma[column], chroma, line_chroma[column], 1'b0)};
					rgb_expected = {rgb_expected, bt601_pixel(ROW_CUR, column, luma,
						chroma, line_chroma[column], 1'b1)};
				end
			end
			waiting <= rgb_expected.size();
		end
		mismatches <= error_total;
	end

endmodule

@@ bench/testbench.sv @@
// testbench: drives column items into chroma_line_pair_to_rgb_core and
// drains its rgb results with random gaps and stalls; verdict from the count
// kept by rgb_pair_checker; depends on clpr_pkg and the core
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import clpr_pkg::*;

	localparam int   LINE_WIDTH     = 320;
	localparam int   TARGET_ITEMS   = 1600;
	// from here on neither side idles
	localparam int   CALM_FROM      = 1400;
	// cycles without any accepted item, far above the worst gap plus stall
	localparam int   WATCHDOG_LIMIT = 2000;
	localparam int   DRAIN_CYCLES   = 20;
	localparam logic STORE_LINE     = 1'b0;
	localparam logic EMIT_LINE      = 1'b1;

	logic             clk         = 1'b0;
	logic             arst_n      = 1'b0;
	logic             push        = 1'b0;
	logic [COL_W-1:0] column      = '0;
	logic [PIX_W-1:0] luma        = '0;
	logic [PIX_W-1:0] chroma      = '0;
	logic             chroma_kind = 1'b0;
	logic             pop         = 1'b0;
	logic             full;
	logic             empty;
	logic             row_select;
	logic [COL_W-1:0] out_column;
	logic [PIX_W-1:0] red;
	logic [PIX_W-1:0] green;
	logic [PIX_W-1:0] blue;
	logic             last;
	int unsigned      mismatches;
	int unsigned      waiting;

	// stimulus bookkeeping: which columns of the line store hold data
	bit               written [LINE_WIDTH];
	int               items_sent = 0;
	bit               calm       = 1'b0;
	bit               gappy      = 1'b1;

	chroma_line_pair_to_rgb_core #(
		.LINE_WIDTH(LINE_WIDTH)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.column     (column),
		.luma       (luma),
		.chroma     (chroma),
		.chroma_kind(chroma_kind),
		.empty      (empty),
		.pop        (pop),
		.row_select (row_select),
		.out_column (out_column),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.last       (last)
	);

	rgb_pair_checker #(
		.LINE_WIDTH(LINE_WIDTH)
	) i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.column     (column),
		.luma       (luma),
		.chroma     (chroma),
		.chroma_kind(chroma_kind),
		.empty      (empty),
		.pop        (pop),
		.row_select (row_select),
		.out_column (out_column),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.last       (last),
		.mismatches (mismatches),
		.waiting    (waiting)
	);

	initial begin
		forever begin
			#5 clk = ~clk;
		end
	end

	// mostly uniform bytes, now and then the edges of the video range
	function automatic logic [PIX_W-1:0] pick_byte();
		case ($urandom_range(0, 9))
			0: return 8'd0;
			1: return 8'd255;
			2: return ($urandom_range(0, 1) != 0) ? 8'd16 : 8'd235;
			default: return PIX_W'($urandom_range(0, 255));
		endcase
	endfunction

	// offer one column item, holding it until the core takes it
	task automatic offer_column(input logic [COL_W-1:0] col, input logic [PIX_W-1:0] y,
			input logic [PIX_W-1:0] c, input logic kind);
		int unsigned gap;
		if ($urandom_range(0, 39) == 0)
			gappy = !gappy;
		if (!calm && gappy && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 10);
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push        <= 1'b1;
		column      <= col;
		luma        <= y;
		chroma      <= c;
		chroma_kind <= kind;
		// full as seen just after the edge is its value at that edge
		do
			@(posedge clk);
		while (full);
		if (col < LINE_WIDTH) begin
			items_sent++;
			if (kind == STORE_LINE)
				written[col] = 1'b1;
		end
		if (items_sent >= CALM_FROM)
			calm = 1'b1;
	endtask

	// result side: random stall bursts, with quiet stretches
	initial begin
		int unsigned stall;
		bit busy;
		busy = 1'b1;
		forever begin
			@(posedge clk);
			if ($urandom_range(0, 63) == 0)
				busy = !busy;
			if (!calm && busy && $urandom_range(0, 4) == 0) begin
				stall = $urandom_range(1, 10);
				pop <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			pop <= 1'b1;
		end
	end

	// nothing accepted on either side for too long ends the run
	initial begin
		int unsigned quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((push && !full) || (pop && !empty))
				quiet = 0;
			else
				quiet++;
		end
		$display("FAIL");
		$finish;
	end

	initial begin
		int n;
		int base;
		int k;
		int order;
		logic [COL_W-1:0] col;
		logic kind;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// darkest input: red and blue clamp at zero
		offer_column(9'd0, 8'd0, 8'd0, STORE_LINE);
		offer_column(9'd0, 8'd0, 8'd0, EMIT_LINE);
		// brightest input at the last column: red and blue clamp at full scale
		offer_column(9'd319, 8'd255, 8'd255, STORE_LINE);
		offer_column(9'd319, 8'd255, 8'd255, EMIT_LINE);
		// black level with neutral chroma gives exact zeros
		offer_column(9'd1, 8'd16, 8'd128, STORE_LINE);
		offer_column(9'd1, 8'd16, 8'd128, EMIT_LINE);
		offer_column(9'd2, 8'd235, 8'd240, STORE_LINE);
		offer_column(9'd2, 8'd128, 8'd16, EMIT_LINE);
		// columns past the line are dropped, storing or emitting
		offer_column(9'd320, 8'd77, 8'd99, STORE_LINE);
		offer_column(9'd320, 8'd77, 8'd99, EMIT_LINE);
		offer_column(9'd511, 8'd255, 8'd255, STORE_LINE);
		offer_column(9'd511, 8'd255, 8'd255, EMIT_LINE);
		offer_column(9'd256, 8'd170, 8'd85, STORE_LINE);
		offer_column(9'd256, 8'd85, 8'd170, EMIT_LINE);
		// overwrite a stored entry, then emit from it twice
		offer_column(9'd0, 8'd255, 8'd0, STORE_LINE);
		offer_column(9'd0, 8'd0, 8'd255, EMIT_LINE);
		offer_column(9'd0, 8'd200, 8'd60, EMIT_LINE);

		while (items_sent < TARGET_ITEMS) begin
			if ($urandom_range(0, 3) != 0) begin
				// a stored segment followed by its emitting partner
				n = $urandom_range(1, 24);
				base = $urandom_range(0, LINE_WIDTH - n);
				for (k = 0; k < n; k++)
					offer_column(COL_W'(base + k), pick_byte(), pick_byte(), STORE_LINE);
				order = $urandom_range(0, 5);
				for (k = 0; k < n; k++) begin
					if (order == 0)
						// scrambled emitting order, columns may repeat
						col = COL_W'(base + $urandom_range(0, n - 1));
					else
						col = COL_W'(base + k);
					if (order != 1 || $urandom_range(0, 3) != 0)
						offer_column(col, pick_byte(), pick_byte(), EMIT_LINE);
				end
			end else begin
				// lone column, sometimes past the line
				if ($urandom_range(0, 3) == 0)
					col = COL_W'($urandom_range(LINE_WIDTH, (1 << COL_W) - 1));
				else
					col = COL_W'($urandom_range(0, LINE_WIDTH - 1));
				kind = $urandom_range(0, 1) != 0 ? EMIT_LINE : STORE_LINE;
				// never emit from a column the store has not seen yet
				if (kind == EMIT_LINE && col < LINE_WIDTH && !written[col])
					kind = STORE_LINE;
				offer_column(col, pick_byte(), pick_byte(), kind);
			end
		end
		push <= 1'b0;

		@(posedge clk);
		while (waiting != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

@@ filelist.f @@
sv/clpr_pkg.sv
sv/clpr_fifo.sv
sv/clpr_front.sv
sv/clpr_back.sv
sv/chroma_line_pair_to_rgb_core.sv
bench/rgb_pair_checker.sv
bench/testbench.sv
